// File: design/tof_pkg.sv
// shared types and constants for the tty output formatter
package tof_pkg;

    localparam int CharW = 7;
    localparam int ByteW = 8;
    localparam int ColW  = 8;
    localparam int IdxW  = 3;
    localparam int DataW = 2;

    localparam logic [IdxW-1:0] CFG_RAW      = 3'd0;
    localparam logic [IdxW-1:0] CFG_EXPTAB   = 3'd1;
    localparam logic [IdxW-1:0] CFG_UPPER    = 3'd2;
    localparam logic [IdxW-1:0] CFG_MAPNL    = 3'd3;
    localparam logic [IdxW-1:0] CFG_NLDLY    = 3'd4;
    localparam logic [IdxW-1:0] CFG_TABDLY   = 3'd5;
    localparam logic [IdxW-1:0] CFG_CRDLY    = 3'd6;
    localparam logic [IdxW-1:0] CFG_VTDLY    = 3'd7;

    localparam logic [1:0] DK_ONE = 2'd1;
    localparam logic [1:0] DK_TWO = 2'd2;

    localparam logic [CharW-1:0] CH_BS     = 7'o010;
    localparam logic [CharW-1:0] CH_TAB    = 7'o011;
    localparam logic [CharW-1:0] CH_NL     = 7'o012;
    localparam logic [CharW-1:0] CH_VT     = 7'o013;
    localparam logic [CharW-1:0] CH_FF     = 7'o014;
    localparam logic [CharW-1:0] CH_CR     = 7'o015;
    localparam logic [CharW-1:0] CH_SPACE  = 7'o040;
    localparam logic [CharW-1:0] CH_TILDE  = 7'o176;
    localparam logic [CharW-1:0] CH_BSLASH = 7'h5c;
    localparam logic [CharW-1:0] CH_LBRACE = 7'h7b;
    localparam logic [CharW-1:0] CH_RBRACE = 7'h7d;
    localparam logic [CharW-1:0] CH_BAR    = 7'h7c;
    localparam logic [CharW-1:0] CH_GRAVE  = 7'h60;
    localparam logic [CharW-1:0] CH_LPAREN = 7'h28;
    localparam logic [CharW-1:0] CH_RPAREN = 7'h29;
    localparam logic [CharW-1:0] CH_BANG   = 7'h21;
    localparam logic [CharW-1:0] CH_CARET  = 7'h5e;
    localparam logic [CharW-1:0] CH_QUOTE  = 7'h27;
    localparam logic [CharW-1:0] CH_LOW_A  = 7'h61;
    localparam logic [CharW-1:0] CH_LOW_Z  = 7'h7a;
    localparam logic [CharW-1:0] CASE_BIT  = 7'h20;

    localparam logic [CharW-1:0] DLY_VT    = 7'o177;
    localparam logic [CharW-1:0] DLY_NLFIX = 7'd6;
    localparam logic [CharW-1:0] DLY_CR1   = 7'd5;
    localparam logic [CharW-1:0] DLY_CR2   = 7'd10;
    localparam logic [CharW-1:0] DLY_TABMIN = 7'd5;
    localparam logic [CharW-1:0] DLY_TABTOP = 7'd9;
    localparam logic [CharW-1:0] DLY_NLADD = 7'd3;

    typedef struct packed {
        logic       raw_mode;
        logic       expand_tabs;
        logic       upper_only;
        logic       map_newline;
        logic [1:0] newline_delay_kind;
        logic [1:0] tab_delay_kind;
        logic [1:0] return_delay_kind;
        logic       vertical_delay;
    } t_cfg;

    typedef struct packed {
        logic [ColW-1:0]  new_col;
        logic [CharW-1:0] delay;
    } t_cook;

endpackage

// File: design/tof_cook.sv
// cooking unit: column update and delay for one 7-bit character
module tof_cook
    import tof_pkg::*;
(
    input  logic [CharW-1:0] i_char,
    input  logic [ColW-1:0]  i_column,
    input  t_cfg             i_cfg,
    output t_cook            o_res
);

    logic [ColW-1:0]  col;
    logic [CharW-1:0] dly;
    logic [CharW-1:0] nl_base;
    logic [CharW-1:0] tab_d;

    assign nl_base = {3'b000, i_column[7:4]} + DLY_NLADD;
    assign tab_d   = DLY_TABTOP - {4'b0000, i_column[2:0]};

    always_comb begin
        col = i_column;
        dly = '0;
        priority if (i_char >= CH_SPACE && i_char <= CH_TILDE) begin
            col = i_column + 8'd1;
        end else if (i_char == CH_BS) begin
            if (i_column != '0) begin
                col = i_column - 8'd1;
            end
        end else if (i_char == CH_NL) begin
            if (i_cfg.newline_delay_kind == DK_ONE) begin
                if (i_column != '0) begin
                    dly = (nl_base < DLY_NLFIX) ? DLY_NLFIX : nl_base;
                end
            end else if (i_cfg.newline_delay_kind == DK_TWO) begin
                dly = DLY_NLFIX;
            end
            col = '0;
        end else if (i_char == CH_TAB) begin
            if (i_cfg.tab_delay_kind == DK_ONE) begin
                dly = (tab_d < DLY_TABMIN) ? '0 : tab_d;
            end
            col = (i_column | 8'd7) + 8'd1;
        end else if (i_char == CH_VT || i_char == CH_FF) begin
            if (i_cfg.vertical_delay) begin
                dly = DLY_VT;
            end
        end else if (i_char == CH_CR) begin
            if (i_cfg.return_delay_kind == DK_ONE) begin
                dly = DLY_CR1;
            end else if (i_cfg.return_delay_kind == DK_TWO) begin
                dly = DLY_CR2;
            end
            col = '0;
        end else begin
            col = i_column;
        end
    end

    assign o_res.new_col = col;
    assign o_res.delay   = dly;

endmodule

// File: design/tty_output_formatter_unit.sv
// top level: sequencer that emits cooked terminal output bytes one per cycle while the output is not stalled
// latency: first byte is offered the cycle after the input transfer
// an item produces n bytes (1 to 8); one byte leaves per cycle through the sequencer
// and cook unit while the output is not stalled
// input ready only while the sequencer is idle
// synchronous reset clears configuration, column and sequencer state
module tty_output_formatter_unit
    import tof_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IdxW-1:0]  i_cfg_idx,
    input  logic [DataW-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ByteW-1:0] i_char_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHR  = 2'd1;
    localparam logic [1:0] ST_DLY  = 2'd2;

    logic [1:0]       r_state, n_state;
    t_cfg             r_cfg, n_cfg;
    logic [ColW-1:0]  r_column, n_column;
    logic [ByteW-1:0] r_cur, n_cur;
    logic [CharW-1:0] r_next, n_next;
    logic             r_has_next, n_has_next;
    logic             r_tab_exp, n_tab_exp;
    logic [CharW-1:0] r_dly, n_dly;

    t_cook            cook;
    logic [CharW-1:0] c7;
    logic [CharW-1:0] folded;
    logic             tab_more;
    logic             out_xfer;

    tof_cook u_cook (
        .i_char   (r_cur[CharW-1:0]),
        .i_column (r_column),
        .i_cfg    (r_cfg),
        .o_res    (cook)
    );

    assign c7       = i_char_in[CharW-1:0];
    assign tab_more = r_tab_exp && (cook.new_col[2:0] != 3'd0);
    assign out_xfer = o_out_valid && i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_CHR) || (r_state == ST_DLY);

    always_comb begin
        o_out_byte = r_cur;
        o_last     = 1'b0;
        unique case (r_state)
            ST_CHR: begin
                o_out_byte = r_cur;
                o_last     = r_cfg.raw_mode ||
                             (cook.delay == '0 && !r_has_next && !tab_more);
            end
            ST_DLY: begin
                o_out_byte = {1'b1, r_dly};
                o_last     = !r_has_next;
            end
            default: begin
                o_out_byte = r_cur;
                o_last     = 1'b0;
            end
        endcase
    end

    // upper-case folding of a plain character
    always_comb begin
        folded = c7;
        if (r_cfg.upper_only && c7 >= CH_LOW_A && c7 <= CH_LOW_Z) begin
            folded = c7 & ~CASE_BIT;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAW:    n_cfg.raw_mode           = i_cfg_data[0];
                CFG_EXPTAB: n_cfg.expand_tabs        = i_cfg_data[0];
                CFG_UPPER:  n_cfg.upper_only         = i_cfg_data[0];
                CFG_MAPNL:  n_cfg.map_newline        = i_cfg_data[0];
                CFG_NLDLY:  n_cfg.newline_delay_kind = i_cfg_data;
                CFG_TABDLY: n_cfg.tab_delay_kind     = i_cfg_data;
                CFG_CRDLY:  n_cfg.return_delay_kind  = i_cfg_data;
                CFG_VTDLY:  n_cfg.vertical_delay     = i_cfg_data[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_column   = r_column;
        n_cur      = r_cur;
        n_next     = r_next;
        n_has_next = r_has_next;
        n_tab_exp  = r_tab_exp;
        n_dly      = r_dly;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state    = ST_CHR;
                    n_has_next = 1'b0;
                    n_tab_exp  = 1'b0;
                    n_cur      = {1'b0, folded};
                    priority if (r_cfg.raw_mode) begin
                        n_cur = i_char_in;
                    end else if (c7 == CH_TAB && r_cfg.expand_tabs) begin
                        n_cur     = {1'b0, CH_SPACE};
                        n_tab_exp = 1'b1;
                    end else if (r_cfg.upper_only && (c7 == CH_LBRACE ||
                                 c7 == CH_RBRACE || c7 == CH_BAR ||
                                 c7 == CH_TILDE || c7 == CH_GRAVE)) begin
                        n_cur      = {1'b0, CH_BSLASH};
                        n_has_next = 1'b1;
                        priority if (c7 == CH_LBRACE) n_next = CH_LPAREN;
                        else if (c7 == CH_RBRACE)     n_next = CH_RPAREN;
                        else if (c7 == CH_BAR)        n_next = CH_BANG;
                        else if (c7 == CH_TILDE)      n_next = CH_CARET;
                        else                          n_next = CH_QUOTE;
                    end else if (c7 == CH_NL && r_cfg.map_newline) begin
                        n_cur      = {1'b0, CH_CR};
                        n_next     = CH_NL;
                        n_has_next = 1'b1;
                    end else begin
                        n_cur = {1'b0, folded};
                    end
                end
            end
            ST_CHR: begin
                if (out_xfer) begin
                    priority if (r_cfg.raw_mode) begin
                        n_state = ST_IDLE;
                    end else if (cook.delay != '0) begin
                        n_column = cook.new_col;
                        n_dly    = cook.delay;
                        n_state  = ST_DLY;
                    end else if (r_has_next) begin
                        n_column   = cook.new_col;
                        n_cur      = {1'b0, r_next};
                        n_has_next = 1'b0;
                    end else if (tab_more) begin
                        n_column = cook.new_col;
                    end else begin
                        n_column = cook.new_col;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_DLY: begin
                if (out_xfer) begin
                    if (r_has_next) begin
                        n_cur      = {1'b0, r_next};
                        n_has_next = 1'b0;
                        n_state    = ST_CHR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cfg      <= '0;
            r_column   <= '0;
            r_has_next <= 1'b0;
            r_tab_exp  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg      <= n_cfg;
            r_column   <= n_column;
            r_has_next <= n_has_next;
            r_tab_exp  <= n_tab_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_next <= n_next;
        r_dly  <= n_dly;
    end

`ifndef ASSERT_OFF
    a_in_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no output after input transfer");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_last) |=> o_in_ready)
        else $error("sequencer busy after final transfer");

    a_dly_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DLY) |-> (o_out_byte[7] && o_out_byte[6:0] != '0))
        else $error("bad delay byte");

    a_cooked_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHR && !r_cfg.raw_mode) |-> !o_out_byte[7])
        else $error("cooked character has bit 7 set");

    a_tab_spaces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHR && r_tab_exp) |-> (r_cur == {1'b0, CH_SPACE} && !r_has_next))
        else $error("tab expansion emits non-space");
`endif

endmodule
